// ===== rtl/adt_pkg.sv =====
// Package for the address keyed depth table: sizes, payload and storage types,
// register map and the bucket hash. No dependencies.
package adt_pkg;

    localparam int TABLE_ENTRIES = 2048;
    localparam int HASH_BUCKETS  = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int BKT_W         = $clog2(HASH_BUCKETS);
    localparam int KEY_W         = 27;
    localparam int PADDR_W       = 3;

    // Register index (paddr[2]) of the only register
    localparam logic REG_RETAIN = 1'b0;
    localparam logic [7:0] RETAIN_RESET = 8'd2;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_FRAME  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] depth_bits;
        logic [31:0] current_word;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic        stale;
        logic [31:0] depth_out;
        logic        overflow;
        logic [11:0] kept_entries;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [31:0]      depth;
        logic [31:0]      gen;
        logic [31:0]      word;
        logic [CNT_W-1:0] link;
    } entry_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] head;
    } bucket_t;

    // Fold the key onto the bucket index
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] h;
        h = key ^ (key >> 11) ^ (key >> 21);
        return h[BKT_W-1:0];
    endfunction

endpackage

// ===== rtl/address_keyed_depth_table.sv =====
// Top level of the address keyed depth table: entry and bucket memories,
// the chain walk and compaction sequencer, APB register. Depends on adt_pkg.

// A record or lookup reads its bucket and, when the bucket is not empty, walks
// the hash chain with one read of the entry memory per chain step. A new frame
// first sweeps the 1024-entry bucket memory and then compacts the table, keeping
// the entries younger than the retain setting and dropping the rest.
// After reset the same bucket sweep runs before the first item is taken; the
// register port works throughout. Items are processed one at a time, and a
// finished result waits in the output register until transferred.
module address_keyed_depth_table (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  adt_pkg::in_item_t       in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output adt_pkg::out_item_t      out_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [adt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import adt_pkg::*;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_BKT, S_CHK, S_CRD, S_CEV, S_CPU, S_OUT
    } state_t;

    state_t           state_reg;
    logic [1:0]       kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [31:0]      depth_reg;
    logic [31:0]      word_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [31:0]      gen_reg;
    logic [7:0]       retain_reg;
    logic [BKT_W-1:0] clr_reg;
    logic             clr_frame_reg;
    logic [CNT_W-1:0] rd_i_reg;
    logic [CNT_W-1:0] wr_n_reg;
    logic             res_hit_reg;
    logic             res_stale_reg;
    logic [31:0]      res_depth_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    entry_t  ent_mem [TABLE_ENTRIES];
    bucket_t bkt_mem [HASH_BUCKETS];
    entry_t  ent_q;
    bucket_t bkt_q;

    logic             ent_re, ent_we, bkt_re, bkt_we;
    logic [IDX_W-1:0] ent_raddr, ent_waddr;
    logic [BKT_W-1:0] bkt_raddr, bkt_waddr;
    entry_t           ent_wdata;
    bucket_t          bkt_wdata;

    logic [KEY_W-1:0] in_key;
    logic             out_free;
    logic [31:0]      age;
    logic             wr_cfg;

    assign in_key   = in_data.address[28:2];
    assign out_free = !out_valid_reg || !out_stall;
    assign age      = gen_reg - ent_q.gen;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign wr_cfg    = psel && penable && pwrite && (paddr[2] == REG_RETAIN);
    assign prdata    = (paddr[2] == REG_RETAIN) ? {24'd0, retain_reg} : 32'd0;

    // Memory control for each state
    always_comb
    begin
        ent_re    = 1'b0;
        ent_raddr = '0;
        ent_we    = 1'b0;
        ent_waddr = '0;
        ent_wdata = ent_q;
        bkt_re    = 1'b0;
        bkt_raddr = '0;
        bkt_we    = 1'b0;
        bkt_waddr = '0;
        bkt_wdata = '0;
        unique case (state_reg)
            S_CLR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
            end
            S_IDLE:
            begin
                bkt_re    = 1'b1;
                bkt_raddr = bucket_of(in_key);
            end
            S_BKT:
            begin
                if (bkt_q.valid && (bkt_q.head < count_reg))
                begin
                    ent_re    = 1'b1;
                    ent_raddr = bkt_q.head[IDX_W-1:0];
                end
                else if (kind_reg == KIND_RECORD && count_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    // Append at the end and push on the chain head
                    ent_we    = 1'b1;
                    ent_waddr = count_reg[IDX_W-1:0];
                    ent_wdata = '{key: key_reg, depth: depth_reg, gen: gen_reg,
                                  word: word_reg,
                                  link: bkt_q.valid ? bkt_q.head : count_reg};
                    bkt_we    = 1'b1;
                    bkt_waddr = bucket_of(key_reg);
                    bkt_wdata = '{valid: 1'b1, head: count_reg};
                end
            end
            S_CHK:
            begin
                if (ent_q.key == key_reg)
                begin
                    if (kind_reg == KIND_RECORD)
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = idx_reg[IDX_W-1:0];
                        ent_wdata = '{key: ent_q.key, depth: depth_reg, gen: gen_reg,
                                      word: word_reg, link: ent_q.link};
                    end
                end
                else if (ent_q.link < idx_reg && ent_q.link < count_reg)
                begin
                    ent_re    = 1'b1;
                    ent_raddr = ent_q.link[IDX_W-1:0];
                end
                else if (kind_reg == KIND_RECORD && count_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    ent_we    = 1'b1;
                    ent_waddr = count_reg[IDX_W-1:0];
                    ent_wdata = '{key: key_reg, depth: depth_reg, gen: gen_reg,
                                  word: word_reg,
                                  link: bkt_q.valid ? bkt_q.head : count_reg};
                    bkt_we    = 1'b1;
                    bkt_waddr = bucket_of(key_reg);
                    bkt_wdata = '{valid: 1'b1, head: count_reg};
                end
            end
            S_CRD:
            begin
                if (rd_i_reg < count_reg)
                begin
                    ent_re    = 1'b1;
                    ent_raddr = rd_i_reg[IDX_W-1:0];
                end
            end
            S_CEV:
            begin
                if (age < {24'd0, retain_reg})
                begin
                    bkt_re    = 1'b1;
                    bkt_raddr = bucket_of(ent_q.key);
                end
            end
            S_CPU:
            begin
                ent_we    = 1'b1;
                ent_waddr = wr_n_reg[IDX_W-1:0];
                ent_wdata = '{key: ent_q.key, depth: ent_q.depth, gen: ent_q.gen,
                              word: ent_q.word,
                              link: bkt_q.valid ? bkt_q.head : wr_n_reg};
                bkt_we    = 1'b1;
                bkt_waddr = bucket_of(ent_q.key);
                bkt_wdata = '{valid: 1'b1, head: wr_n_reg};
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (ent_re)
            ent_q <= ent_mem[ent_raddr];
    end

    // Bucket memory
    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_waddr] <= bkt_wdata;
        if (bkt_re)
            bkt_q <= bkt_mem[bkt_raddr];
    end

    // Sequencer, status and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            clr_frame_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            gen_reg       <= '0;
            retain_reg    <= RETAIN_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            kind_reg      <= '0;
            key_reg       <= '0;
            depth_reg     <= '0;
            word_reg      <= '0;
            idx_reg       <= '0;
            rd_i_reg      <= '0;
            wr_n_reg      <= '0;
            res_hit_reg   <= 1'b0;
            res_stale_reg <= 1'b0;
            res_depth_reg <= '0;
        end
        else
        begin
            if (wr_cfg)
                retain_reg <= pwdata[7:0];
            // Drop a transferred result unless a new one is loaded this cycle
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BKT_W'(HASH_BUCKETS - 1))
                    begin
                        rd_i_reg  <= '0;
                        wr_n_reg  <= '0;
                        state_reg <= clr_frame_reg ? S_CRD : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    res_hit_reg   <= 1'b0;
                    res_stale_reg <= 1'b0;
                    res_depth_reg <= '0;
                    if (in_valid)
                    begin
                        kind_reg  <= in_data.kind;
                        key_reg   <= in_key;
                        depth_reg <= in_data.depth_bits;
                        word_reg  <= in_data.current_word;
                        unique case (in_data.kind)
                            KIND_RECORD, KIND_LOOKUP: state_reg <= S_BKT;
                            KIND_FRAME:
                            begin
                                gen_reg       <= gen_reg + 32'd1;
                                clr_reg       <= '0;
                                clr_frame_reg <= 1'b1;
                                state_reg     <= S_CLR;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_BKT:
                begin
                    if (bkt_q.valid && (bkt_q.head < count_reg))
                    begin
                        idx_reg   <= bkt_q.head;
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        if (kind_reg == KIND_RECORD)
                        begin
                            if (count_reg < CNT_W'(TABLE_ENTRIES))
                                count_reg <= count_reg + 1'b1;
                            else
                                ovf_reg <= 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_CHK:
                begin
                    if (ent_q.key == key_reg)
                    begin
                        if (kind_reg == KIND_LOOKUP)
                        begin
                            res_hit_reg   <= (ent_q.word == word_reg);
                            res_stale_reg <= (ent_q.word != word_reg);
                            res_depth_reg <= (ent_q.word == word_reg) ? ent_q.depth : 32'd0;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (ent_q.link < idx_reg && ent_q.link < count_reg)
                    begin
                        idx_reg <= ent_q.link;
                    end
                    else
                    begin
                        if (kind_reg == KIND_RECORD)
                        begin
                            if (count_reg < CNT_W'(TABLE_ENTRIES))
                                count_reg <= count_reg + 1'b1;
                            else
                                ovf_reg <= 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_CRD:
                begin
                    if (rd_i_reg < count_reg)
                        state_reg <= S_CEV;
                    else
                    begin
                        count_reg     <= wr_n_reg;
                        ovf_reg       <= 1'b0;
                        clr_frame_reg <= 1'b0;
                        state_reg     <= S_OUT;
                    end
                end
                S_CEV:
                begin
                    if (age < {24'd0, retain_reg})
                        state_reg <= S_CPU;
                    else
                    begin
                        rd_i_reg  <= rd_i_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                end
                S_CPU:
                begin
                    wr_n_reg  <= wr_n_reg + 1'b1;
                    rd_i_reg  <= rd_i_reg + 1'b1;
                    state_reg <= S_CRD;
                end
                S_OUT:
                begin
                    // Hand the result over once the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= '{hit: res_hit_reg, stale: res_stale_reg,
                                           depth_out: res_depth_reg, overflow: ovf_reg,
                                           kept_entries: 12'(count_reg)};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks on the sequencer
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transfer taken while busy");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRD || state_reg == S_CEV || state_reg == S_CPU) |->
        (wr_n_reg <= rd_i_reg))
        else $error("compaction write ran ahead of read");

endmodule
